>>> hw/rtl/sle_pkg.sv
// ---------------------------------------------------------------------------
// sle_pkg
// shared types, constants and the key translation table of the line editor
// ---------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int CHAR_W     = 7;

  // scan code set 1 key numbers
  localparam logic [6:0] KEY_LIMIT  = 7'd58;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_BKSP   = 7'h0E;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] KEY_ENTER  = 7'h1C;

  // configuration register indexes
  localparam logic REG_ECHO = 1'b0;
  localparam logic REG_LINE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef logic [CHAR_W-1:0] char_t;

  // key number to ascii, zero where the key has no character
  localparam char_t KEY_TABLE [0:58] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00
  };

endpackage

`default_nettype wire

>>> hw/rtl/sle_ram.sv
// ---------------------------------------------------------------------------
// sle_ram
// generic single-port ram, one optional write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/scancode_line_editor.sv
// ---------------------------------------------------------------------------
// scancode_line_editor
// set-1 scan codes in, echo / erase events and completed lines out
// ---------------------------------------------------------------------------
// decode: a code is taken in S_IDLE and decoded in S_DECODE, which waits for
//   a free output and then loads a single echo or erase result into the output
//   register; a new code is taken only in S_IDLE, after the last is decoded;
//   Enter streams a stored line out of the single ram port, alternating S_READ
//   and S_LOAD per character; S_LOAD waits while the output is stalled
// reset: rst clears the flags, the fill count, the sequencer and the output
//   valid; the line store is not cleared, only written entries are ever read
// ---------------------------------------------------------------------------
`default_nettype none

module scancode_line_editor
  import sle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // input stream
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] scan_code
  // result stream
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [6:0] char_code, [7] zero
  output logic [1:0]      m_tuser,   // [1:0] kind
  output logic            m_tlast,   // last
  // configuration writes
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data
);

  // sequencer: take a code, decode it, and for Enter alternate ram read and
  // output load until the whole line has gone out
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_READ   = 4'b0100,
    S_LOAD   = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [7:0]        code;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [ADDR_W-1:0] rd_idx, rd_idx_next;
  logic              shift_held, shift_held_next;
  logic              caps_on, caps_on_next;
  logic              echo_enable, line_enable;

  // output register
  logic              load;
  kind_t             load_kind;
  char_t             load_char;
  logic              load_last;
  logic              out_free;

  // line store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  char_t             ram_rdata;

  // decode of the held code
  logic [6:0]        key;
  logic              down;
  char_t             raw_char;
  char_t             key_char;
  logic              printable;
  logic              line_full;
  logic              is_last;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign key  = code[6:0];
  assign down = !code[7];

  // table lookup only meaningful for keys up to the limit
  always_comb begin
    raw_char = '0;
    if (key <= KEY_LIMIT) begin
      raw_char = KEY_TABLE[key[5:0]];
    end
  end

  // case flip: lower-case letters become upper when shift and caps differ
  always_comb begin
    key_char = raw_char;
    if ((shift_held != caps_on) && (raw_char >= 7'h61) && (raw_char <= 7'h7A)) begin
      key_char = raw_char ^ 7'h20;
    end
  end

  assign printable = (key_char >= 7'h20) && (key_char != 7'h7F);
  assign line_full = (fill == CNT_W'(LINE_DEPTH));
  assign is_last   = ((CNT_W'(rd_idx) + CNT_W'(1)) == fill);

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    rd_idx_next     = rd_idx;
    shift_held_next = shift_held;
    caps_on_next    = caps_on;
    load            = 1'b0;
    load_kind       = KIND_ECHO;
    load_char       = '0;
    load_last       = 1'b1;
    ram_we          = 1'b0;
    ram_addr        = rd_idx;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end

      // wait for a free output so that any single result can be loaded
      S_DECODE: begin
        if (out_free) begin
          state_next = S_IDLE;
          if (key > KEY_LIMIT) begin
            // ignored code
          end else if ((key == KEY_LSHIFT) || (key == KEY_RSHIFT)) begin
            shift_held_next = down;
          end else if (!down) begin
            // release of any other key
          end else if (key == KEY_BKSP) begin
            if (fill != '0) begin
              fill_next = fill - 1'b1;
              load      = echo_enable;
              load_kind = KIND_ERASE;
            end
          end else if (key == KEY_CAPS) begin
            caps_on_next = !caps_on;
          end else if (key == KEY_ENTER) begin
            if (!line_enable) begin
              fill_next = '0;
            end else if (fill == '0) begin
              load      = 1'b1;
              load_kind = KIND_EMPTY;
            end else begin
              rd_idx_next = '0;
              state_next  = S_READ;
            end
          end else if (printable && !line_full) begin
            ram_we    = 1'b1;
            ram_addr  = fill[ADDR_W-1:0];
            fill_next = fill + 1'b1;
            load      = echo_enable;
            load_kind = KIND_ECHO;
            load_char = key_char;
          end
        end
      end

      // address presented this cycle, data registered for the next
      S_READ: begin
        state_next = S_LOAD;
      end

      S_LOAD: begin
        if (out_free) begin
          load      = 1'b1;
          load_kind = KIND_LINE;
          load_char = ram_rdata;
          load_last = is_last;
          if (is_last) begin
            fill_next  = '0;
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
            state_next  = S_READ;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  sle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (key_char),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      rd_idx      <= '0;
      shift_held  <= 1'b0;
      caps_on     <= 1'b0;
      echo_enable <= 1'b0;
      line_enable <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      rd_idx     <= rd_idx_next;
      shift_held <= shift_held_next;
      caps_on    <= caps_on_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ECHO: echo_enable <= cfg_data;
          REG_LINE: line_enable <= cfg_data;
          default:  ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      code <= s_tdata;
    end
    if (load) begin
      m_tdata <= {1'b0, load_char};
      m_tuser <= load_kind;
      m_tlast <= load_last;
    end
  end

endmodule

`default_nettype wire
